// File: src/cbfr_pkg.sv
// Shared types and constants for the complemented byte frame receiver.
// Used by the front end, the descriptor queue, the back end and the top level.
`timescale 1ns / 1ps
`default_nettype none

package cbfr_pkg;

    // Header bytes that open a frame, and the complement mask.
    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hFF;
    localparam logic [7:0] SYNC_THIRD  = 8'h00;
    localparam logic [7:0] COMPL_MASK  = 8'hFF;

    // Even-byte store: two banks of 64 bytes each.
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int DESC_DEPTH  = 2;

    // Store write from the front end.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // One finished message waiting to be emitted.
    typedef struct packed {
        logic             bank;
        logic [IDX_W-1:0] len;
    } t_desc;

    // Bank handed back by the back end after its last read.
    typedef struct packed {
        logic en;
        logic bank;
    } t_release;

endpackage

`default_nettype wire

// File: src/cbfr_front.sv
// Front end: header hunt, complement check, even-byte storage and message check.
// Depends on cbfr_pkg; writes the store in cbfr_back and feeds cbfr_desc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module cbfr_front #(
    parameter int RX_BUFFER_BYTES = 128
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic [cbfr_pkg::IDX_W-1:0] i_max_length,
    input  wire cbfr_pkg::t_release        i_release,
    output logic                           o_bank_busy,
    output cbfr_pkg::t_mem_wr              o_mem_wr,
    output logic                           o_desc_push,
    output cbfr_pkg::t_desc                o_desc
);
    import cbfr_pkg::*;

    localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SYNC1 = 2'd1,
        PH_SYNC2 = 2'd2,
        PH_DATA  = 2'd3
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_count, n_count;
    logic [7:0]      r_sum, n_sum;
    logic [7:0]      r_last, n_last;
    logic [7:0]      r_tail, n_tail;
    logic            r_bank, n_bank;
    logic [1:0]      r_busy, n_busy;

    logic             fail;
    logic             bad_compl;
    logic             has_room;
    logic             match;
    logic [IDX_W-1:0] msg_count;
    logic [IDX_W-1:0] msg_len;
    logic [CW-2:0]    half_count;
    logic [CW-2:0]    n_half_count;

    assign half_count   = r_count[CW-1:1];
    assign n_half_count = n_count[CW-1:1];
    assign bad_compl    = r_count[0] && ((i_rx_byte ^ r_last) != COMPL_MASK);
    assign has_room     = r_count < CW'(RX_BUFFER_BYTES);
    assign o_bank_busy  = r_busy[r_bank];

    // Next-state logic for one received byte.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_last    = r_last;
        n_tail    = r_tail;
        fail      = 1'b0;
        match     = 1'b0;
        o_mem_wr  = '0;
        o_mem_wr.addr = {r_bank, IDX_W'(half_count)};
        o_mem_wr.data = i_rx_byte;

        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_rx_byte == SYNC_FIRST) n_phase = PH_SYNC1;
                end
                PH_SYNC1: begin
                    if (i_rx_byte == SYNC_SECOND) n_phase = PH_SYNC2;
                    else fail = 1'b1;
                end
                PH_SYNC2: begin
                    if (i_rx_byte == SYNC_THIRD) begin
                        n_count = '0;
                        n_sum   = '0;
                        n_phase = PH_DATA;
                    end else begin
                        fail = 1'b1;
                    end
                end
                PH_DATA: begin
                    if (bad_compl || !has_room) begin
                        fail = 1'b1;
                    end else begin
                        if (!r_count[0]) begin
                            o_mem_wr.en = 1'b1;
                            n_sum       = r_sum + i_rx_byte;
                            n_tail      = i_rx_byte;
                        end else if (r_count != CW'(1)) begin
                            // Odd byte closes a pair: test the running checksum.
                            match = (r_tail == (r_sum - r_tail));
                        end
                        n_last  = i_rx_byte;
                        n_count = r_count + CW'(1);
                    end
                end
                default: n_phase = PH_IDLE;
            endcase

            // Restart the header hunt after a rejected byte.
            if (fail) begin
                if (i_rx_byte == SYNC_FIRST) begin
                    n_phase = PH_SYNC1;
                end else if (i_rx_byte == SYNC_SECOND && r_phase == PH_DATA &&
                             r_count != '0 && r_last == SYNC_FIRST) begin
                    n_phase = PH_SYNC2;
                end else begin
                    n_phase = PH_IDLE;
                end
            end

            if (match) n_phase = PH_IDLE;
        end
    end

    // Message length: earlier even bytes, clamped to the configured maximum.
    assign msg_count   = IDX_W'(n_half_count) - IDX_W'(1);
    assign msg_len     = (msg_count > i_max_length) ? i_max_length : msg_count;
    assign o_desc_push = match && (msg_len != '0);
    assign o_desc.bank = r_bank;
    assign o_desc.len  = msg_len;

    // Bank ownership: set when a message is queued, cleared on release.
    always_comb begin
        n_busy = r_busy;
        n_bank = r_bank;
        if (i_release.en) n_busy[i_release.bank] = 1'b0;
        if (o_desc_push) begin
            n_busy[r_bank] = 1'b1;
            n_bank         = ~r_bank;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_last  <= '0;
            r_tail  <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_last  <= n_last;
            r_tail  <= n_tail;
            r_bank  <= n_bank;
            r_busy  <= n_busy;
        end
    end

endmodule

`default_nettype wire

// File: src/cbfr_desc_fifo.sv
// Two-entry queue of message descriptors between the front and back ends.
// Depends on cbfr_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cbfr_desc_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cbfr_pkg::t_desc i_desc,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output cbfr_pkg::t_desc      o_desc
);
    import cbfr_pkg::*;

    localparam int PW = $clog2(DESC_DEPTH);

    t_desc         r_entries [DESC_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_entries[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_entries[r_wr_ptr] <= i_desc;
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/cbfr_back.sv
// Back end: holds the two-bank even-byte store and walks it to emit payload bytes.
// Depends on cbfr_pkg; written by cbfr_front, fed by cbfr_desc_fifo.
`timescale 1ns / 1ps
`default_nettype none

module cbfr_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire cbfr_pkg::t_mem_wr          i_mem_wr,
    input  wire logic                       i_desc_valid,
    input  wire cbfr_pkg::t_desc            i_desc,
    output logic                            o_desc_pop,
    output cbfr_pkg::t_release              o_release,
    input  wire logic                       i_out_pop,
    output logic                            o_out_valid,
    output logic [7:0]                      o_payload_byte,
    output logic [cbfr_pkg::IDX_W-1:0]      o_byte_index,
    output logic                            o_last_of_message
);
    import cbfr_pkg::*;

    logic [7:0]       r_mem [2*STORE_DEPTH];
    logic             r_active;
    logic             r_bank;
    logic [IDX_W-1:0] r_len;
    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_rd_data;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;

    logic issue;
    logic is_last;

    assign issue      = r_active && (!r_out_valid || i_out_pop);
    assign is_last    = (r_idx == (r_len - IDX_W'(1)));
    assign o_desc_pop = !r_active && i_desc_valid;

    assign o_release.en   = issue && is_last;
    assign o_release.bank = r_bank;

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_rd_data;
    assign o_byte_index      = r_out_idx;
    assign o_last_of_message = r_out_last;

    // Store: one write port from the front, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        if (issue) r_rd_data <= r_mem[{r_bank, r_idx}];
    end

    // Payload sideband that travels with the read data.
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out_idx  <= r_idx;
            r_out_last <= is_last;
        end
    end

    // Walk control and the output transaction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_bank      <= 1'b0;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + IDX_W'(1);
                if (is_last) r_active <= 1'b0;
            end else if (i_out_pop) begin
                r_out_valid <= 1'b0;
            end

            if (o_desc_pop) begin
                r_active <= 1'b1;
                r_bank   <= i_desc.bank;
                r_len    <= i_desc.len;
                r_idx    <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/complemented_byte_frame_receiver.sv
// Complemented byte frame receiver, top level. Input accepts one byte per cycle
// while the front bank is free; full rises when both store banks hold queued messages.
// A message's descriptor is registered in the queue on its closing byte; once idle, the
// back end takes it and gives one payload byte per cycle while pop is held; the store
// read port sets that rate. Synchronous active-low reset returns to the header hunt and
// empties both queues; the store itself is not cleared and max_length resets to 63.
`timescale 1ns / 1ps
`default_nettype none

module complemented_byte_frame_receiver #(
    parameter int RX_BUFFER_BYTES = 128
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 i_rx_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      o_payload_byte,
    output logic [cbfr_pkg::IDX_W-1:0]      o_byte_index,
    output logic                            o_last_of_message,
    input  wire logic                       i_cfg_we,
    input  wire logic [cbfr_pkg::IDX_W-1:0] i_cfg_wdata
);
    import cbfr_pkg::*;

    logic [IDX_W-1:0] r_max_length;
    logic             bank_busy;
    logic             in_accept;
    logic             out_valid;
    t_mem_wr          mem_wr;
    logic             desc_push;
    t_desc            desc_in;
    logic             desc_valid;
    t_desc            desc_out;
    logic             desc_pop;
    t_release         bank_release;

    assign full      = bank_busy;
    assign in_accept = push && !bank_busy;
    assign empty     = !out_valid;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= IDX_W'(63);
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    cbfr_front #(
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_rx_byte    (i_rx_byte),
        .i_max_length (r_max_length),
        .i_release    (bank_release),
        .o_bank_busy  (bank_busy),
        .o_mem_wr     (mem_wr),
        .o_desc_push  (desc_push),
        .o_desc       (desc_in)
    );

    cbfr_desc_fifo u_desc_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_desc  (desc_in),
        .i_pop   (desc_pop),
        .o_valid (desc_valid),
        .o_desc  (desc_out)
    );

    cbfr_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mem_wr          (mem_wr),
        .i_desc_valid      (desc_valid),
        .i_desc            (desc_out),
        .o_desc_pop        (desc_pop),
        .o_release         (bank_release),
        .i_out_pop         (pop),
        .o_out_valid       (out_valid),
        .o_payload_byte    (o_payload_byte),
        .o_byte_index      (o_byte_index),
        .o_last_of_message (o_last_of_message)
    );

endmodule

`default_nettype wire

// File: src/cbfr_checker.sv
// Port-level checks for the complemented byte frame receiver, bound to the top level.
// Depends on cbfr_pkg for the index width.
`timescale 1ns / 1ps
`default_nettype none

module cbfr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic [7:0]                 o_payload_byte,
    input wire logic [cbfr_pkg::IDX_W-1:0] o_byte_index,
    input wire logic                       o_last_of_message
);
    import cbfr_pkg::*;

    // Reset leaves no result transaction pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_payload_byte) &&
                              $stable(o_byte_index) && $stable(o_last_of_message)))
        else $error("waiting result changed before pop");

    // Byte positions within a message count up by one.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_of_message) |=>
            (empty || o_byte_index == $past(o_byte_index) + IDX_W'(1)))
        else $error("byte index did not advance by one");

    // A new message starts at position zero.
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_of_message) |=> (empty || o_byte_index == '0))
        else $error("message did not start at index zero");

    // Positions never reach 63.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_index != IDX_W'(63)))
        else $error("byte index out of range");

endmodule

bind complemented_byte_frame_receiver cbfr_checker u_cbfr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .empty             (empty),
    .pop               (pop),
    .o_payload_byte    (o_payload_byte),
    .o_byte_index      (o_byte_index),
    .o_last_of_message (o_last_of_message)
);

`default_nettype wire

// File: verif/tb_complemented_byte_frame_receiver.sv
// Self-checking testbench for the complemented byte frame receiver.
// Depends on cbfr_pkg and complemented_byte_frame_receiver; an internal predictor
// builds the expected payload transactions, and a monitor compares them with the block.
`timescale 1ns / 1ps

module tb_complemented_byte_frame_receiver;

    import cbfr_pkg::*;

    localparam int RX_BUFFER_BYTES = 128;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TIMEOUT_NS      = 5_000_000;
    localparam int ITEMS_PER_PHASE = 8;

    typedef enum logic [1:0] {
        RX_IDLE,
        RX_SYNC1,
        RX_SYNC2,
        RX_DATA
    } t_rx_phase;

    typedef struct {
        logic [7:0]       payload;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_payload_exp;

    // Clock and block ports.
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    logic [7:0]       i_rx_byte = 8'h00;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       o_payload_byte;
    logic [IDX_W-1:0] o_byte_index;
    logic             o_last_of_message;
    logic             i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_wdata = '0;

    // Predictor state.
    t_rx_phase        pred_phase;
    int unsigned      pred_count;
    logic [7:0]       pred_store [STORE_DEPTH];
    logic [7:0]       pred_last;
    logic [7:0]       pred_sum;
    logic [IDX_W-1:0] pred_max_len;

    t_payload_exp     expected_payload_q [$];
    t_payload_exp     got_exp;
    int               fail_count = 0;
    int               sent_count = 0;
    int unsigned      pop_stall_left = 0;
    bit               send_gaps_on = 1'b1;
    bit               pop_stalls_on = 1'b1;

    always #5 i_clk = ~i_clk;

    complemented_byte_frame_receiver #(
        .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_last_of_message(o_last_of_message),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Phase to fall back to when a byte breaks the frame.
    function automatic t_rx_phase resync_phase(input logic [7:0] b, input bit from_data);
        if (b == SYNC_FIRST) return RX_SYNC1;
        if (b == SYNC_SECOND && from_data && pred_count > 0 && pred_last == SYNC_FIRST)
            return RX_SYNC2;
        return RX_IDLE;
    endfunction

    // Advance the predictor by one accepted byte and queue any payload it releases.
    task automatic predict_rx_byte(input logic [7:0] b);
        bit           broken;
        t_rx_phase    nxt;
        int unsigned  n;
        logic [7:0]   tail;
        logic [7:0]   check;
        t_payload_exp e;
        broken = 1'b0;
        nxt = pred_phase;
        case (pred_phase)
            RX_IDLE: begin
                if (b == SYNC_FIRST) nxt = RX_SYNC1;
            end
            RX_SYNC1: begin
                if (b == SYNC_SECOND) nxt = RX_SYNC2;
                else broken = 1'b1;
            end
            RX_SYNC2: begin
                if (b == SYNC_THIRD) begin
                    pred_count = 0;
                    pred_sum = 8'h00;
                    nxt = RX_DATA;
                end else begin
                    broken = 1'b1;
                end
            end
            default: begin
                if (pred_count[0] && ((b ^ pred_last) != COMPL_MASK)) begin
                    broken = 1'b1;
                end else if (pred_count < RX_BUFFER_BYTES) begin
                    if (!pred_count[0]) begin
                        pred_store[(pred_count >> 1) % STORE_DEPTH] = b;
                        pred_sum = pred_sum + b;
                    end
                    pred_last = b;
                    pred_count++;
                end else begin
                    broken = 1'b1;
                end
            end
        endcase
        if (broken) nxt = resync_phase(b, pred_phase == RX_DATA);
        pred_phase = nxt;

        // The last even byte closes the message when it equals the sum of the others.
        if (pred_phase == RX_DATA && pred_count > 3 && !pred_count[0]) begin
            n = (pred_count >> 1) - 1;
            tail = pred_store[n % STORE_DEPTH];
            check = pred_sum - tail;
            if (tail == check) begin
                if (n > pred_max_len) n = pred_max_len;
                for (int i = 0; i < n; i++) begin
                    e.payload = pred_store[i % STORE_DEPTH];
                    e.index = i[IDX_W-1:0];
                    e.last = (i + 1 == n);
                    expected_payload_q.push_back(e);
                end
                pred_phase = RX_IDLE;
            end
        end
    endtask

    // Offer one byte, wait for its transaction, then maybe leave a gap.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (!push) push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        sent_count++;
        predict_rx_byte(b);
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic hold_input();
        if (push) push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_results_drained();
        while (expected_payload_q.size() != 0) @(posedge i_clk);
    endtask

    // The register is only written with the input held and every result out.
    task automatic write_max_length(input logic [IDX_W-1:0] v);
        hold_input();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pred_max_len = v;
    endtask

    // Header plus n_pairs of byte and complement. Only the last pair may close the
    // message; tail_aa makes the last stored byte 0xAA and its complement 0x55; a pair
    // at break_at gets a bad complement and ends the frame early.
    task automatic send_frame(input int n_pairs, input bit closes, input bit tail_aa,
                              input int break_at);
        logic [7:0] sum;
        logic [7:0] v;
        logic [7:0] mask;
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_THIRD);
        sum = 8'h00;
        for (int k = 0; k < n_pairs; k++) begin
            if (closes && k == n_pairs - 1) begin
                v = sum;
            end else if (tail_aa && k == n_pairs - 1) begin
                v = 8'hAA;
            end else begin
                v = 8'($urandom);
                while ((k >= 1 && v == sum) ||
                       (tail_aa && k == n_pairs - 2 && v == 8'hAA - sum))
                    v = 8'($urandom);
            end
            send_byte(v);
            if (k == break_at) begin
                mask = 8'($urandom_range(1, 255));
                send_byte(v ^ COMPL_MASK ^ mask);
                return;
            end
            send_byte(v ^ COMPL_MASK);
            sum = sum + v;
        end
    endtask

    // A short frame with the byte extremes as payload.
    task automatic test_basic_frames();
        send_byte(8'h55); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h00); send_byte(8'hFF);
        send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'hFF); send_byte(8'h00);
    endtask

    // Wrong header bytes, a bad complement, and the resync through a stored 0x55.
    task automatic test_resync_cases();
        send_byte(8'h55); send_byte(8'h55); send_byte(8'hFF); send_byte(8'h55);
        send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h12); send_byte(8'h13);
        send_byte(8'h55); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h55); send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01); send_byte(8'hFE); send_byte(8'h01); send_byte(8'hFE);
    endtask

    // Clamping at the register extremes.
    task automatic test_max_length_extremes();
        write_max_length(IDX_W'(1));
        send_frame(4, 1'b1, 1'b0, -1);
        write_max_length(IDX_W'(0));
        send_frame(3, 1'b1, 1'b0, -1);
        write_max_length(IDX_W'(63));
        send_frame(10, 1'b1, 1'b0, -1);
    endtask

    // Fill the buffer without a match and overflow it into the resync through a final 0x55,
    // then break a frame with a 0x55 that restarts the hunt at the first sync state.
    task automatic test_full_buffer();
        write_max_length(IDX_W'(63));
        send_frame(64, 1'b0, 1'b1, -1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h07); send_byte(8'hF8); send_byte(8'h07); send_byte(8'hF8);
        send_byte(8'h55); send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h12); send_byte(8'h55);
        send_byte(8'hFF); send_byte(8'h00);
        send_byte(8'h01); send_byte(8'hFE); send_byte(8'h01); send_byte(8'hFE);
    endtask

    // Mostly valid frames with random content, mixed with broken frames and noise.
    task automatic test_random_traffic();
        int          phase_end;
        int unsigned r;
        int          n_pairs;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_max_length(IDX_W'($urandom_range(1, 63)));
                1: write_max_length(IDX_W'($urandom_range(1, 4)));
                default: write_max_length(IDX_W'(63));
            endcase
            phase_end = sent_count + ITEMS_PER_PHASE;
            while (sent_count < phase_end) begin
                send_gaps_on = ($urandom_range(0, 3) != 0);
                pop_stalls_on = ($urandom_range(0, 3) != 0);
                n_pairs = ($urandom_range(0, 9) != 0) ? $urandom_range(2, 6)
                                                      : $urandom_range(7, 20);
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    send_frame(n_pairs, 1'b1, 1'b0, -1);
                end else if (r < 80) begin
                    send_frame(n_pairs, 1'b1, 1'b0, $urandom_range(0, n_pairs - 1));
                end else if (r < 88) begin
                    send_frame(n_pairs, 1'b0, 1'b0, -1);
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 3))
                            0: send_byte(SYNC_FIRST);
                            1: send_byte(SYNC_SECOND);
                            2: send_byte(SYNC_THIRD);
                            default: send_byte(8'($urandom));
                        endcase
                    end
                end
            end
        end
        send_gaps_on = 1'b1;
        pop_stalls_on = 1'b1;
    endtask

    // Compare each popped transaction with the oldest expectation, then pace pop.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_payload_q.size() == 0) begin
                $error("unexpected payload transaction: payload_byte %0h, byte_index %0d",
                       o_payload_byte, o_byte_index);
                fail_count++;
            end else begin
                got_exp = expected_payload_q.pop_front();
                if (o_payload_byte !== got_exp.payload) begin
                    $error("payload_byte: expected %0h, actual %0h",
                           got_exp.payload, o_payload_byte);
                    fail_count++;
                end
                if (o_byte_index !== got_exp.index) begin
                    $error("byte_index: expected %0d, actual %0d",
                           got_exp.index, o_byte_index);
                    fail_count++;
                end
                if (o_last_of_message !== got_exp.last) begin
                    $error("last_of_message: expected %0b, actual %0b",
                           got_exp.last, o_last_of_message);
                    fail_count++;
                end
            end
        end
        if (pop_stall_left > 0) begin
            pop <= 1'b0;
            pop_stall_left--;
        end else begin
            pop <= 1'b1;
            if (pop_stalls_on && $urandom_range(0, 3) == 0) pop_stall_left = pick_gap();
        end
    end

    initial begin
        pred_phase = RX_IDLE;
        pred_count = 0;
        pred_last = 8'h00;
        pred_sum = 8'h00;
        pred_max_len = IDX_W'(63);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_frames();
        test_resync_cases();
        test_max_length_extremes();
        test_full_buffer();
        test_random_traffic();

        hold_input();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
src/cbfr_pkg.sv
src/cbfr_front.sv
src/cbfr_desc_fifo.sv
src/cbfr_back.sv
src/complemented_byte_frame_receiver.sv
src/cbfr_checker.sv
verif/tb_complemented_byte_frame_receiver.sv
